// ===== hdl/tlnf_pkg.sv =====
// ----------------------------------------------------------------------------
// tlnf_pkg
// Shared types and character constants for the text line number filter.
// ----------------------------------------------------------------------------
package tlnf_pkg;

    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5e;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CTRL_MAX  = 8'd31;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CARET_OFS = 8'd64;

    localparam logic [1:0] BLANK_SAT = 2'd3;
    localparam logic [1:0] BLANK_SQZ = 2'd2;
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    typedef enum logic [2:0] {
        REG_NUMBER_NONBLANK = 3'd0,
        REG_NUMBER_ALL      = 3'd1,
        REG_SQUEEZE_BLANK   = 3'd2,
        REG_SHOW_ENDS       = 3'd3,
        REG_SHOW_TABS       = 3'd4,
        REG_SHOW_NONPRINT   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic number_nonblank;
        logic number_all;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprint;
    } cfg_t;

    // one queued job: what the back end has to emit for one input byte
    typedef struct packed {
        logic       num;
        logic       dollar;
        logic [1:0] tail_len;
        logic [7:0] tail0;
        logic [7:0] tail1;
    } desc_t;

endpackage

// ===== hdl/tlnf_in_if.sv =====
// ----------------------------------------------------------------------------
// tlnf_in_if
// Raw text byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlnf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== hdl/tlnf_out_if.sv =====
// ----------------------------------------------------------------------------
// tlnf_out_if
// Filtered text byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlnf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;

    modport source (output valid, output out_byte, output run_end, input ready);
    modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface

// ===== hdl/text_line_number_filter.sv =====
// ----------------------------------------------------------------------------
// text_line_number_filter
// Streaming text filter: line numbers, blank squeezing, visible ends, tabs
// and control bytes.
// ----------------------------------------------------------------------------
// One raw byte is taken per cycle while the two-entry job queue has room; the
// front end classifies it and updates the line counter in that same cycle.
// The back end emits one output word per cycle unless the output port stalls;
// a byte yields one word for plain text, two for caret forms, and up to
// NUMBER_COLUMNS+3 when a line number opens the line (nine at the default).
// Squeezed blank lines produce nothing and push no job. Output words reach the
// port in the cycle after the back end picks them, through a registered stage.
// Sustained throughput is set by the output port at one byte per cycle while
// it is ready. Registers sit on the APB port at byte addresses 0, 4, .. 20;
// the user must write them only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module text_line_number_filter
    import tlnf_pkg::*;
#(
    parameter int NUMBER_COLUMNS = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]   prdata,
    output logic                    pready,
    tlnf_in_if.sink                 raw,
    tlnf_out_if.source              filtered
);

    localparam int QW    = $bits(desc_t) + 8 * NUMBER_COLUMNS;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cfg_t                        cfg_reg, cfg_next;
    logic                        cfg_wr;
    logic                        rd_bit;

    logic                        push, pop, q_full, q_valid;
    desc_t                       push_desc, head_desc;
    logic [8*NUMBER_COLUMNS-1:0] push_chars, head_chars;
    logic [CNT_W-1:0]            q_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        rd_bit   = 1'b0;
        unique case (cfg_idx_t'(paddr[4:2]))
            REG_NUMBER_NONBLANK:
            begin
                cfg_next.number_nonblank = pwdata[0];
                rd_bit = cfg_reg.number_nonblank;
            end
            REG_NUMBER_ALL:
            begin
                cfg_next.number_all = pwdata[0];
                rd_bit = cfg_reg.number_all;
            end
            REG_SQUEEZE_BLANK:
            begin
                cfg_next.squeeze_blank = pwdata[0];
                rd_bit = cfg_reg.squeeze_blank;
            end
            REG_SHOW_ENDS:
            begin
                cfg_next.show_ends = pwdata[0];
                rd_bit = cfg_reg.show_ends;
            end
            REG_SHOW_TABS:
            begin
                cfg_next.show_tabs = pwdata[0];
                rd_bit = cfg_reg.show_tabs;
            end
            REG_SHOW_NONPRINT:
            begin
                cfg_next.show_nonprint = pwdata[0];
                rd_bit = cfg_reg.show_nonprint;
            end
            default:
            begin
                cfg_next = cfg_reg;
                rd_bit   = 1'b0;
            end
        endcase
    end

    assign prdata = {{(CFG_DATA_W-1){1'b0}}, rd_bit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            cfg_reg <= cfg_next;
        end
    end

    tlnf_front #(
        .NUMBER_COLUMNS (NUMBER_COLUMNS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .raw       (raw),
        .q_full    (q_full),
        .push      (push),
        .desc      (push_desc),
        .num_chars (push_chars)
    );

    tlnf_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_desc, push_chars}),
        .pop        (pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_data  ({head_desc, head_chars}),
        .count      (q_count)
    );

    tlnf_back #(
        .NUMBER_COLUMNS (NUMBER_COLUMNS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .desc       (head_desc),
        .num_chars  (head_chars),
        .pop        (pop),
        .filtered   (filtered)
    );

    // queue never holds more jobs than it has entries
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("job queue count out of range");

    // a job retires only from a non-empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty job queue");

    // a word that is not the last of its run leaves its job still queued
    a_run_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (filtered.valid && filtered.ready && !filtered.run_end) |-> q_valid)
        else $error("run ended without run_end word");

    // the job at the head keeps its contents until it retires
    a_head_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !pop) |=> (q_valid && $stable(head_desc)))
        else $error("job queue head changed before retire");

endmodule

// ===== hdl/tlnf_front.sv =====
// ----------------------------------------------------------------------------
// tlnf_front
// Accepts raw bytes, tracks line state and the decimal line counter, and
// builds one job per byte that produces output.
// ----------------------------------------------------------------------------
module tlnf_front
    import tlnf_pkg::*;
#(
    parameter int NUMBER_COLUMNS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    tlnf_in_if.sink                       raw,
    input  logic                          q_full,
    output logic                          push,
    output desc_t                         desc,
    output logic [8*NUMBER_COLUMNS-1:0]   num_chars
);

    logic                 after_nl_reg, after_nl_next;
    logic [1:0]           blank_run_reg, blank_run_next;
    logic [3:0]           digits_reg  [NUMBER_COLUMNS];
    logic [3:0]           digits_next [NUMBER_COLUMNS];

    logic                 accept;
    logic                 nl;
    logic                 squeezed;
    logic [7:0]           c;

    assign raw.ready = !q_full;
    assign accept    = raw.valid && raw.ready;
    assign c         = raw.in_byte;
    assign nl        = (c == CH_NL);

    always_comb
    begin
        if (nl && after_nl_reg)
        begin
            blank_run_next = (blank_run_reg == BLANK_SAT) ? BLANK_SAT
                                                          : blank_run_reg + 2'd1;
        end
        else
        begin
            blank_run_next = 2'd0;
        end
        squeezed      = cfg.squeeze_blank && (blank_run_next >= BLANK_SQZ);
        after_nl_next = nl;
    end

    // job descriptor
    always_comb
    begin
        desc = '0;
        if (cfg.number_nonblank)
        begin
            desc.num = !nl && after_nl_reg;
        end
        else
        begin
            desc.num = cfg.number_all && after_nl_reg && !squeezed;
        end
        desc.dollar = cfg.show_ends && nl && !squeezed;

        if (cfg.show_tabs && (c == CH_TAB))
        begin
            desc.tail_len = 2'd2;
            desc.tail0    = CH_CARET;
            desc.tail1    = CH_I;
        end
        else if (cfg.show_nonprint && !nl && (c != CH_TAB) && (c <= CTRL_MAX))
        begin
            desc.tail_len = 2'd2;
            desc.tail0    = CH_CARET;
            desc.tail1    = c + CARET_OFS;
        end
        else if (cfg.show_nonprint && (c == CH_DEL))
        begin
            desc.tail_len = 2'd2;
            desc.tail0    = CH_CARET;
            desc.tail1    = c - CARET_OFS;
        end
        else if (!squeezed)
        begin
            desc.tail_len = 2'd1;
            desc.tail0    = c;
        end
    end

    assign push = accept && (desc.num || desc.dollar || (desc.tail_len != 2'd0));

    // line number text, most significant column first, leading zeros blanked
    always_comb
    begin
        logic leading;
        leading = 1'b1;
        for (int k = 0; k < NUMBER_COLUMNS; k++)
        begin
            if ((digits_reg[NUMBER_COLUMNS-1-k] != 4'd0) || (k == NUMBER_COLUMNS - 1))
            begin
                leading = 1'b0;
            end
            num_chars[8*k +: 8] = leading ? CH_SPACE
                                          : (CH_ZERO + {4'd0, digits_reg[NUMBER_COLUMNS-1-k]});
        end
    end

    // decimal increment, holds at all nines
    always_comb
    begin
        logic carry;
        logic full;
        carry = 1'b1;
        full  = 1'b1;
        for (int i = 0; i < NUMBER_COLUMNS; i++)
        begin
            if (digits_reg[i] != DIGIT_MAX)
            begin
                full = 1'b0;
            end
        end
        for (int i = 0; i < NUMBER_COLUMNS; i++)
        begin
            digits_next[i] = digits_reg[i];
            if (carry && !full)
            begin
                digits_next[i] = (digits_reg[i] == DIGIT_MAX) ? 4'd0 : digits_reg[i] + 4'd1;
            end
            carry = carry && (digits_reg[i] == DIGIT_MAX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_nl_reg  <= 1'b1;
            blank_run_reg <= 2'd0;
            for (int i = 0; i < NUMBER_COLUMNS; i++)
            begin
                digits_reg[i] <= (i == 0) ? 4'd1 : 4'd0;
            end
        end
        else if (accept)
        begin
            after_nl_reg  <= after_nl_next;
            blank_run_reg <= blank_run_next;
            if (desc.num)
            begin
                for (int i = 0; i < NUMBER_COLUMNS; i++)
                begin
                    digits_reg[i] <= digits_next[i];
                end
            end
        end
    end

endmodule

// ===== hdl/tlnf_queue.sv =====
// ----------------------------------------------------------------------------
// tlnf_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module tlnf_queue
    import tlnf_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  logic [WIDTH-1:0]                      push_data,
    input  logic                                  pop,
    output logic                                  full,
    output logic                                  head_valid,
    output logic [WIDTH-1:0]                      head_data,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]      count
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hdl/tlnf_back.sv =====
// ----------------------------------------------------------------------------
// tlnf_back
// Expands the job at the queue head into output words, one byte per cycle
// while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module tlnf_back
    import tlnf_pkg::*;
#(
    parameter int NUMBER_COLUMNS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  desc_t                         desc,
    input  logic [8*NUMBER_COLUMNS-1:0]   num_chars,
    output logic                          pop,
    tlnf_out_if.source                    filtered
);

    localparam int PW = $clog2(NUMBER_COLUMNS + 5);

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] num_len, pre_len, total_len;
    logic          last;
    logic          adv;
    logic [7:0]    sel_byte;
    logic [7:0]    digit_char;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          run_end_reg;

    assign num_len   = desc.num ? PW'(NUMBER_COLUMNS + 1) : '0;
    assign pre_len   = num_len + PW'(desc.dollar);
    assign total_len = pre_len + PW'(desc.tail_len);
    assign last      = ((pos_reg + PW'(1)) == total_len);

    assign adv = head_valid && (!out_valid_reg || filtered.ready);
    assign pop = adv && last;

    always_comb
    begin
        digit_char = CH_SPACE;
        for (int k = 0; k < NUMBER_COLUMNS; k++)
        begin
            if (pos_reg == PW'(k))
            begin
                digit_char = num_chars[8*k +: 8];
            end
        end
    end

    always_comb
    begin
        if (pos_reg < num_len)
        begin
            sel_byte = (pos_reg < PW'(NUMBER_COLUMNS)) ? digit_char : CH_TAB;
        end
        else if (pos_reg < pre_len)
        begin
            sel_byte = CH_DOLLAR;
        end
        else if (pos_reg == pre_len)
        begin
            sel_byte = desc.tail0;
        end
        else
        begin
            sel_byte = desc.tail1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= last ? '0 : pos_reg + PW'(1);
            end
            else if (filtered.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg <= sel_byte;
            run_end_reg  <= last;
        end
    end

    assign filtered.valid    = out_valid_reg;
    assign filtered.out_byte = out_byte_reg;
    assign filtered.run_end  = run_end_reg;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text line number filter. A driver pushes raw
// bytes on the input channel, a monitor takes filtered words from the output
// channel, and each word is compared with a byte-level model of the filter.
// The run goes through several register settings and idle patterns on both
// sides, with directed bytes first and weighted random text after.
// ----------------------------------------------------------------------------
module tb_top;
    import tlnf_pkg::*;

    localparam int NCOLS        = 6;
    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 32;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
    } out_word_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    tlnf_in_if  raw_if ();
    tlnf_out_if filt_if ();

    text_line_number_filter #(
        .NUMBER_COLUMNS (NCOLS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .raw      (raw_if),
        .filtered (filt_if)
    );

    // filter model state
    cfg_t       cfg_model;
    logic       after_nl;
    logic [1:0] blank_run;
    logic [3:0] line_no [NCOLS];

    logic [7:0] bytes_to_send [$];
    out_word_t  bytes_due [$];
    int         sent_total;
    int         taken_total;
    int         fail_count;
    int         send_idle_pct;
    int         recv_stall_pct;
    logic       drv_hold;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic flag_mismatch(input string what, input out_word_t want,
                                 input out_word_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, what, want.text, want.last, got.text, got.last);
    endtask

    // computes the words one raw byte produces and advances the model
    function automatic void filter_byte(input logic [7:0] c);
        logic       nl;
        logic       squeezed;
        logic       done;
        logic       do_num;
        logic       leading;
        logic       full;
        logic       carry;
        logic [7:0] run [$];
        out_word_t  w;

        nl = (c == CH_NL);
        if (nl && after_nl)
        begin
            if (blank_run < BLANK_SAT)
                blank_run++;
        end
        else
            blank_run = '0;
        squeezed = cfg_model.squeeze_blank && (blank_run >= BLANK_SQZ);

        if (cfg_model.number_nonblank)
            do_num = !nl && after_nl;
        else
            do_num = cfg_model.number_all && after_nl && !squeezed;

        if (do_num)
        begin
            leading = 1'b1;
            for (int i = NCOLS - 1; i >= 0; i--)
            begin
                if (line_no[i] != 0 || i == 0)
                    leading = 1'b0;
                run.push_back(leading ? CH_SPACE : CH_ZERO + 8'(line_no[i]));
            end
            run.push_back(CH_TAB);
            full = 1'b1;
            for (int i = 0; i < NCOLS; i++)
                if (line_no[i] != DIGIT_MAX)
                    full = 1'b0;
            // counter sticks at all nines
            if (!full)
            begin
                carry = 1'b1;
                for (int i = 0; i < NCOLS; i++)
                    if (carry)
                    begin
                        if (line_no[i] < DIGIT_MAX)
                        begin
                            line_no[i]++;
                            carry = 1'b0;
                        end
                        else
                            line_no[i] = '0;
                    end
            end
        end

        if (cfg_model.show_ends && nl && !squeezed)
            run.push_back(CH_DOLLAR);

        done = 1'b0;
        if (cfg_model.show_tabs && c == CH_TAB)
        begin
            run.push_back(CH_CARET);
            run.push_back(CH_I);
            done = 1'b1;
        end

        if (cfg_model.show_nonprint && !nl && c != CH_TAB)
        begin
            if (c <= CTRL_MAX)
            begin
                run.push_back(CH_CARET);
                run.push_back(c + CARET_OFS);
                done = 1'b1;
            end
            else if (c == CH_DEL)
            begin
                run.push_back(CH_CARET);
                run.push_back(c - CARET_OFS);
                done = 1'b1;
            end
        end

        if (!squeezed && !done)
            run.push_back(c);

        after_nl = nl;

        foreach (run[i])
        begin
            w.text = run[i];
            w.last = (i == run.size() - 1);
            bytes_due.push_back(w);
        end
    endfunction

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            raw_if.valid   <= 1'b0;
            raw_if.in_byte <= '0;
        end
        else
        begin
            drv_hold = raw_if.valid;
            if (raw_if.valid && raw_if.ready)
            begin
                filter_byte(raw_if.in_byte);
                taken_total++;
                drv_hold = 1'b0;
            end
            if (!drv_hold)
            begin
                if (bytes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    raw_if.valid   <= 1'b1;
                    raw_if.in_byte <= bytes_to_send.pop_front();
                end
                else
                    raw_if.valid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            filt_if.ready <= 1'b0;
        else
        begin
            if (filt_if.valid && filt_if.ready)
            begin
                if (bytes_due.size() == 0)
                    flag_mismatch("word with none expected", '0,
                                  {filt_if.out_byte, filt_if.run_end});
                else if (bytes_due[0] !== {filt_if.out_byte, filt_if.run_end})
                    flag_mismatch("word mismatch", bytes_due.pop_front(),
                                  {filt_if.out_byte, filt_if.run_end});
                else
                    void'(bytes_due.pop_front());
            end
            filt_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic bit0);
        logic [CFG_DATA_W-1:0] data;

        // upper bits are noise, only bit 0 counts
        data = ($urandom() << 1) | CFG_DATA_W'(bit0);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NUMBER_NONBLANK: cfg_model.number_nonblank = bit0;
            REG_NUMBER_ALL:      cfg_model.number_all      = bit0;
            REG_SQUEEZE_BLANK:   cfg_model.squeeze_blank   = bit0;
            REG_SHOW_ENDS:       cfg_model.show_ends       = bit0;
            REG_SHOW_TABS:       cfg_model.show_tabs       = bit0;
            REG_SHOW_NONPRINT:   cfg_model.show_nonprint   = bit0;
            default: ;
        endcase
    endtask

    task automatic load_cfg(input cfg_t c);
        reg_write(REG_NUMBER_NONBLANK, c.number_nonblank);
        reg_write(REG_NUMBER_ALL,      c.number_all);
        reg_write(REG_SQUEEZE_BLANK,   c.squeeze_blank);
        reg_write(REG_SHOW_ENDS,       c.show_ends);
        reg_write(REG_SHOW_TABS,       c.show_tabs);
        reg_write(REG_SHOW_NONPRINT,   c.show_nonprint);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
            3:       begin send_idle_pct = 28; recv_stall_pct = 28; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    function automatic void queue_byte(input logic [7:0] b);
        bytes_to_send.push_back(b);
        sent_total++;
    endfunction

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;

        r = $urandom_range(99);
        if (r < 22)
            return CH_NL;
        else if (r < 30)
            return CH_TAB;
        else if (r < 40)
            return 8'($urandom_range(31));
        else if (r < 44)
            return CH_DEL;
        else if (r < 58)
            return 8'($urandom_range(255, 128));
        else
            return 8'($urandom_range(126, 32));
    endfunction

    function automatic void queue_random(input int n);
        int k;
        int blanks;

        k = 0;
        while (k < n)
        begin
            // runs of blank lines reach the squeeze logic
            if ($urandom_range(9) == 0)
            begin
                blanks = $urandom_range(4, 2);
                for (int j = 0; j < blanks; j++)
                    queue_byte(CH_NL);
                k += blanks;
            end
            else
            begin
                queue_byte(pick_byte());
                k++;
            end
        end
    endfunction

    // waits until all bytes are taken and the words drain or time out
    task automatic drain();
        int waited;

        while (taken_total != sent_total)
            @(posedge clk);
        waited = 0;
        while (bytes_due.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        while (bytes_due.size() > 0)
            flag_mismatch("word never arrived", bytes_due.pop_front(), '0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        cfg_t c;

        raw_if.valid   = 1'b0;
        raw_if.in_byte = '0;
        filt_if.ready  = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;

        cfg_model   = '0;
        after_nl    = 1'b1;
        blank_run   = '0;
        foreach (line_no[i])
            line_no[i] = '0;
        line_no[0]  = 4'd1;
        sent_total  = 0;
        taken_total = 0;
        fail_count  = 0;
        set_idle(0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain pass-through, extremes of the byte
        load_cfg('0);
        queue_byte(8'h00);
        queue_byte(8'hff);
        queue_byte(CH_NL);
        queue_byte(CH_TAB);
        queue_byte(CH_DEL);
        drain();

        // everything visible, numbered lines, squeezed blank lines
        c = '1;
        c.number_nonblank = 1'b0;
        load_cfg(c);
        queue_text("a\t");
        queue_byte(8'h00);
        queue_byte(8'h1f);
        queue_byte(CH_DEL);
        queue_byte(8'h80);
        queue_byte(8'hff);
        queue_text("\n\n\n\n\nb\n");
        drain();

        // both numbering bits on, tab left alone by nonprint
        c = '0;
        c.number_nonblank = 1'b1;
        c.number_all      = 1'b1;
        c.show_nonprint   = 1'b1;
        load_cfg(c);
        queue_text("\t\n\nx");
        queue_byte(8'h01);
        queue_byte(CH_NL);
        drain();

        // writes to missing registers are dropped
        reg_write(3'd6, 1'b1);
        reg_write(3'd7, 1'b1);
        c = '0;
        c.number_all = 1'b1;
        load_cfg(c);
        set_idle(3);
        // carry the line counter past two digits
        for (int i = 0; i < 100; i++)
            queue_byte(CH_NL);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            if (p == 0)
                c = '1;
            else if (p == 1)
                c = '0;
            else
                c = cfg_t'(6'($urandom_range(63)));
            load_cfg(c);
            set_idle(p % 4);
            queue_random(12);
            drain();
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
